>>> hdl/dpd_pkg.sv
// Package for the depth pixel deprojection block.
// Holds field widths, register indexes, sequencer states and fixed-point helpers.
// Depends on nothing; every other file of the block imports it.
package dpd_pkg;

    // Frame size bounds.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int CAP_WIDTH  = (MAX_WIDTH  < 4096) ? MAX_WIDTH  : 4096;
    localparam int CAP_HEIGHT = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;

    // Field and register widths.
    localparam int SIZE_W   = 13;
    localparam int CNT_W    = 12;
    localparam int CENTER_W = 16;
    localparam int INV_W    = 24;
    localparam int DEPTH_W  = 16;
    localparam int COORD_W  = 28;
    localparam int Z_W      = 20;
    localparam int MAG_W    = 16;
    localparam int HALF_W   = 20;
    localparam int PROD_W   = INV_W + DEPTH_W;
    localparam int ACC_W    = PROD_W + MAG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

    // Sequence steps of the shared multiplier.
    localparam logic [STEP_W-1:0] STEP_X_T    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_X_LO   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_X_HI   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_Y_T    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_Y_LO   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_Y_HI   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_Y_DONE = 3'd6;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_LOAD = 3'b100
    } dpd_state_t;

    // Saturation limits of a coordinate.
    localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    // Effective frame size: zero acts as one, large values clamp to the cap.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size,
                                                   input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] s;
        begin
            s = size;
            if (s == '0)
            begin
                s = SIZE_W'(1);
            end
            if (s > cap)
            begin
                s = cap;
            end
            return s;
        end
    endfunction

    // Round the exact product to nearest (ties away from zero), apply the sign
    // and saturate to the coordinate range.
    function automatic logic [COORD_W-1:0] round_sat(input logic [ACC_W-1:0] acc,
                                                     input logic neg);
        logic [ACC_W:0]        sum;
        logic [ACC_W-24:0]     q;
        logic [COORD_W-1:0]    res;
        begin
            sum = {1'b0, acc} + (ACC_W+1)'(24'h800000);
            q   = sum[ACC_W:24];
            if (neg)
            begin
                if (q > (ACC_W-23)'(SAT_NEG))
                begin
                    res = SAT_NEG;
                end
                else
                begin
                    res = -q[COORD_W-1:0];
                end
            end
            else
            begin
                if (q > (ACC_W-23)'(SAT_POS))
                begin
                    res = SAT_POS;
                end
                else
                begin
                    res = q[COORD_W-1:0];
                end
            end
            return res;
        end
    endfunction

endpackage

>>> hdl/dpd_in_if.sv
// Input channel of the depth pixel deprojection block: one depth pixel per transfer.
// Depends on dpd_pkg for the field widths.
interface dpd_in_if
    import dpd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_mm;
    logic               in_mask;

    modport source (output valid, output depth_mm, output in_mask, input ready);
    modport sink   (input valid, input depth_mm, input in_mask, output ready);
endinterface

>>> hdl/dpd_out_if.sv
// Output channel of the depth pixel deprojection block: one point or frame end per transfer.
// Depends on dpd_pkg for the field widths.
interface dpd_out_if
    import dpd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x_q4;
    logic signed [COORD_W-1:0] point_y_q4;
    logic [Z_W-1:0]            point_z_q4;
    logic                      point_valid;
    logic                      frame_end;

    modport source (output valid, output point_x_q4, output point_y_q4, output point_z_q4,
                    output point_valid, output frame_end, input ready);
    modport sink   (input valid, input point_x_q4, input point_y_q4, input point_z_q4,
                    input point_valid, input frame_end, output ready);
endinterface

>>> hdl/depth_pixel_deprojection.sv
// Path: a pixel that yields a point goes through the calc steps and the load state into the output
// register; a frame end without a point goes through the load state only; other pixels give no result.
// Sequencing: one shared 24x16 multiplier runs seven sequencer steps per point, and no new pixel is
// taken until a point or frame end has been loaded; other pixels are taken back to back, and
// the output register lets the next pixel enter while a result waits. Reset (rst_n,
// asynchronous, active low) clears the counters and restores every configuration register.
module depth_pixel_deprojection
    import dpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dpd_in_if.sink                in_ch,
    dpd_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [SIZE_W-1:0]   frame_width_reg;
    logic [SIZE_W-1:0]   frame_height_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;

    // Control state.
    dpd_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic                out_valid_reg, out_valid_next;

    // Per-pixel working registers.
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [MAG_W-1:0]    mag_x_reg, mag_x_next;
    logic [MAG_W-1:0]    mag_y_reg, mag_y_next;
    logic                neg_x_reg, neg_x_next;
    logic                neg_y_reg, neg_y_next;
    logic                point_reg, point_next;
    logic                fend_reg, fend_next;
    logic [PROD_W-1:0]   t_reg, t_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [COORD_W-1:0]  x_res_reg, x_res_next;
    logic [COORD_W-1:0]  y_res_reg, y_res_next;

    // Output registers.
    logic [COORD_W-1:0]  out_x_reg, out_x_next;
    logic [COORD_W-1:0]  out_y_reg, out_y_next;
    logic [Z_W-1:0]      out_z_reg, out_z_next;
    logic                out_pv_reg, out_pv_next;
    logic                out_fe_reg, out_fe_next;

    // Frame geometry of the current pixel.
    logic [SIZE_W-1:0]   w_eff, h_eff;
    logic                last_col, last_row, frame_last, is_point, in_xfer, load;
    logic [CNT_W-1:0]    pos_x, pos_y;
    logic signed [MAG_W+1:0] off_x, off_y;

    // Shared multiplier.
    logic [INV_W-1:0]    mul_a;
    logic [MAG_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // Counter decode and pixel offsets.
    always_comb
    begin
        w_eff      = eff_size(frame_width_reg, SIZE_W'(CAP_WIDTH));
        h_eff      = eff_size(frame_height_reg, SIZE_W'(CAP_HEIGHT));
        last_col   = ({1'b0, col_reg} + SIZE_W'(1)) >= w_eff;
        last_row   = ({1'b0, row_reg} + SIZE_W'(1)) >= h_eff;
        frame_last = last_col && last_row;
        is_point   = in_ch.in_mask && (in_ch.depth_mm != '0);
        pos_x      = ({1'b0, col_reg} >= w_eff) ? CNT_W'(w_eff - SIZE_W'(1)) : col_reg;
        pos_y      = ({1'b0, row_reg} >= h_eff) ? CNT_W'(h_eff - SIZE_W'(1)) : row_reg;
        off_x      = $signed({2'b00, pos_x, 4'b0000}) - $signed({2'b00, center_x_reg});
        off_y      = $signed({2'b00, pos_y, 4'b0000}) - $signed({2'b00, center_y_reg});
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (step_reg)
            STEP_X_T:
            begin
                mul_a = inv_focal_x_reg;
                mul_b = depth_reg;
            end
            STEP_X_LO:
            begin
                mul_a = INV_W'(t_reg[HALF_W-1:0]);
                mul_b = mag_x_reg;
            end
            STEP_X_HI:
            begin
                mul_a = INV_W'(t_reg[PROD_W-1:HALF_W]);
                mul_b = mag_x_reg;
            end
            STEP_Y_T:
            begin
                mul_a = inv_focal_y_reg;
                mul_b = depth_reg;
            end
            STEP_Y_LO:
            begin
                mul_a = INV_W'(t_reg[HALF_W-1:0]);
                mul_b = mag_y_reg;
            end
            STEP_Y_HI:
            begin
                mul_a = INV_W'(t_reg[PROD_W-1:HALF_W]);
                mul_b = mag_y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        depth_next     = depth_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        point_next     = point_reg;
        fend_next      = fend_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        x_res_next     = x_res_reg;
        y_res_next     = y_res_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_pv_next    = out_pv_reg;
        out_fe_next    = out_fe_reg;
        load           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Capture the pixel and advance the raster counters.
                    depth_next = in_ch.depth_mm;
                    neg_x_next = off_x[MAG_W+1];
                    neg_y_next = off_y[MAG_W+1];
                    mag_x_next = off_x[MAG_W+1] ? MAG_W'(-off_x) : MAG_W'(off_x);
                    mag_y_next = off_y[MAG_W+1] ? MAG_W'(-off_y) : MAG_W'(off_y);
                    point_next = is_point;
                    fend_next  = frame_last;
                    step_next  = STEP_X_T;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + CNT_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CNT_W'(1);
                    end
                    if (is_point)
                    begin
                        state_next = ST_CALC;
                    end
                    else if (frame_last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + STEP_W'(1);
                case (step_reg)
                    STEP_X_T:
                    begin
                        t_next = mul_p;
                    end
                    STEP_X_LO, STEP_Y_LO:
                    begin
                        acc_next = ACC_W'(mul_p);
                    end
                    STEP_X_HI, STEP_Y_HI:
                    begin
                        acc_next = acc_reg + (ACC_W'(mul_p) << HALF_W);
                    end
                    STEP_Y_T:
                    begin
                        t_next     = mul_p;
                        x_res_next = round_sat(acc_reg, neg_x_reg);
                    end
                    STEP_Y_DONE:
                    begin
                        y_res_next = round_sat(acc_reg, neg_y_reg);
                        state_next = ST_LOAD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_LOAD:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    load        = 1'b1;
                    out_x_next  = point_reg ? x_res_reg : '0;
                    out_y_next  = point_reg ? y_res_reg : '0;
                    out_z_next  = point_reg ? {depth_reg, 4'b0000} : '0;
                    out_pv_next = point_reg;
                    out_fe_next = fend_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_X_T;
            col_reg          <= '0;
            row_reg          <= '0;
            out_valid_reg    <= 1'b0;
            frame_width_reg  <= SIZE_W'(1280);
            frame_height_reg <= SIZE_W'(720);
            center_x_reg     <= CENTER_W'(10240);
            center_y_reg     <= CENTER_W'(5760);
            inv_focal_x_reg  <= INV_W'(26214);
            inv_focal_y_reg  <= INV_W'(26214);
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                    REG_CENTER_X:     center_x_reg     <= cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:     center_y_reg     <= cfg_data[CENTER_W-1:0];
                    REG_INV_FOCAL_X:  inv_focal_x_reg  <= cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y:  inv_focal_y_reg  <= cfg_data[INV_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        depth_reg  <= depth_next;
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        point_reg  <= point_next;
        fend_reg   <= fend_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        x_res_reg  <= x_res_next;
        y_res_reg  <= y_res_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_z_reg  <= out_z_next;
        out_pv_reg <= out_pv_next;
        out_fe_reg <= out_fe_next;
    end

    // Output channel.
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.point_x_q4  = $signed(out_x_reg);
    assign out_ch.point_y_q4  = $signed(out_y_reg);
    assign out_ch.point_z_q4  = out_z_reg;
    assign out_ch.point_valid = out_pv_reg;
    assign out_ch.frame_end   = out_fe_reg;

endmodule

>>> hdl/dpd_checker.sv
// Port-level checker for the depth pixel deprojection block, bound to the top level.
// Depends on dpd_pkg for the field widths.
module dpd_checker
    import dpd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COORD_W-1:0] point_x_q4,
    input logic [COORD_W-1:0] point_y_q4,
    input logic [Z_W-1:0]     point_z_q4,
    input logic               point_valid,
    input logic               frame_end
);

    // A stalled result stays offered with the same coordinates, depth and frame end flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x_q4)
            && $stable(point_y_q4) && $stable(point_z_q4) && $stable(frame_end))
        else $error("stalled result changed or was dropped");

    // A result without a point is a frame end with all coordinates cleared.
    a_empty_is_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> frame_end && point_x_q4 == '0
            && point_y_q4 == '0 && point_z_q4 == '0)
        else $error("result without a point is not a clean frame end");

    // A real point carries nonzero depth scaled to sixteenths.
    a_point_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> point_z_q4 != '0 && point_z_q4[3:0] == 4'b0000)
        else $error("point with zero or misaligned depth");

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered straight after reset");

endmodule

bind depth_pixel_deprojection dpd_checker u_dpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .point_x_q4  (out_ch.point_x_q4),
    .point_y_q4  (out_ch.point_y_q4),
    .point_z_q4  (out_ch.point_z_q4),
    .point_valid (out_ch.point_valid),
    .frame_end   (out_ch.frame_end)
);
